FILE: rtl/ddg_pkg.sv
package ddg_pkg;

    localparam int VALUE_W        = 32;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int FONT_ROWS      = 8;
    localparam int FONT_W         = 8;
    localparam int ROW_BITS       = 80;
    localparam int ROW_CNT_W      = 4;
    localparam int COUNT_W        = 4;

    localparam int DEF_GLYPH_ROWS  = 8;
    localparam int DEF_GLYPH_WIDTH = 8;
    localparam int DEF_MAX_DIGITS  = 10;

    localparam logic [FONT_W-1:0] FONT_ROM [0:FONT_ROWS-1][0:BCD_DIGITS-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3E, 8'h0C, 8'h1E, 8'h1E, 8'h06, 8'h3F, 8'h1E, 8'h7F, 8'h1E, 8'h1E},
        '{8'h63, 8'h1C, 8'h33, 8'h33, 8'h0E, 8'h30, 8'h33, 8'h03, 8'h33, 8'h33},
        '{8'h63, 8'h0C, 8'h33, 8'h03, 8'h16, 8'h30, 8'h30, 8'h06, 8'h33, 8'h33},
        '{8'h63, 8'h0C, 8'h06, 8'h0C, 8'h36, 8'h3E, 8'h3E, 8'h0C, 8'h1E, 8'h1F},
        '{8'h63, 8'h0C, 8'h0C, 8'h03, 8'h66, 8'h03, 8'h33, 8'h18, 8'h33, 8'h03},
        '{8'h63, 8'h0C, 8'h18, 8'h33, 8'h7F, 8'h03, 8'h33, 8'h30, 8'h33, 8'h33},
        '{8'h3E, 8'h3F, 8'h3F, 8'h1E, 8'h06, 8'h3E, 8'h1E, 8'h60, 8'h1E, 8'h1E}
    };

    // bcd codes above nine never occur, they read as blank
    function automatic logic [FONT_W-1:0] font_row(input logic [2:0] row,
                                                   input logic [3:0] dig);
        logic [FONT_W-1:0] g;
        g = '0;
        if (dig <= 4'd9) begin
            g = FONT_ROM[row][dig];
        end
        return g;
    endfunction

endpackage

FILE: rtl/decimal_digit_glyph_renderer.sv
// the first row strobes after start is taken and the bit-serial conversion ends, then one row per cycle
// start is taken only in idle, so a new value waits until its last row is out; busy is high
// through the bit-serial binary to bcd conversion and then while the GLYPH_ROWS rows are emitted
// the receiver cannot stall, each row is on the ports for one cycle under o_valid
// synchronous active-low reset returns the sequencer to idle and drops o_valid
module decimal_digit_glyph_renderer
    import ddg_pkg::*;
#(
    parameter int GLYPH_ROWS  = DEF_GLYPH_ROWS,
    parameter int GLYPH_WIDTH = DEF_GLYPH_WIDTH,
    parameter int MAX_DIGITS  = DEF_MAX_DIGITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [VALUE_W-1:0]   i_value,
    output logic                 busy,
    output logic                 o_valid,
    output logic [2:0]           o_row_index,
    output logic [15:0]          o_pixels_high,
    output logic [63:0]          o_pixels_low,
    output logic [COUNT_W-1:0]   o_digit_count,
    output logic                 o_last
);

    localparam int BIT_CNT_W = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_W-1:0]     r_value;
    logic [BCD_W-1:0]       r_bcd;
    logic [BCD_W-1:0]       n_bcd;
    logic [BIT_CNT_W-1:0]   r_bit_cnt;
    logic [ROW_CNT_W-1:0]   r_row;
    logic                   r_valid;
    logic [2:0]             r_row_index;
    logic [ROW_BITS-1:0]    r_pixels;
    logic [ROW_BITS-1:0]    n_pixels;
    logic [COUNT_W-1:0]     r_digit_count;
    logic [COUNT_W-1:0]     n_digit_count;
    logic                   r_last;
    logic [BCD_W-1:0]       w_adj;

    // add-3 correction on every digit before the shift
    for (genvar d = 0; d < BCD_DIGITS; d++) begin : g_adj
        logic [3:0] dig;
        assign dig = r_bcd[4*d +: 4];
        assign w_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end

    assign n_bcd = {w_adj[BCD_W-2:0], r_value[VALUE_W-1]};

    // position of the highest nonzero digit, zero still counts one digit
    always_comb begin
        n_digit_count = COUNT_W'(1);
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] != 4'd0) begin
                n_digit_count = COUNT_W'(d + 1);
            end
        end
    end

    // cell p holds bcd digit p, rightmost cell at the low end of the row
    for (genvar p = 0; p < ROW_BITS / GLYPH_WIDTH; p++) begin : g_cell
        logic [FONT_W-1:0] glyph;
        logic              shown;
        assign glyph = font_row(r_row[2:0], r_bcd[4*(p % BCD_DIGITS) +: 4]);
        assign shown = (p < MAX_DIGITS) && (COUNT_W'(p) < n_digit_count)
                       && (r_row < ROW_CNT_W'(FONT_ROWS));
        assign n_pixels[p*GLYPH_WIDTH +: GLYPH_WIDTH] =
            shown ? glyph[GLYPH_WIDTH-1:0] : '0;
    end
    if ((ROW_BITS / GLYPH_WIDTH) * GLYPH_WIDTH < ROW_BITS) begin : g_pad
        assign n_pixels[ROW_BITS-1:(ROW_BITS / GLYPH_WIDTH) * GLYPH_WIDTH] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_bit_cnt <= '0;
            r_row     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_value   <= i_value;
                        r_bcd     <= '0;
                        r_bit_cnt <= '0;
                        r_row     <= '0;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd     <= n_bcd;
                    r_value   <= {r_value[VALUE_W-2:0], 1'b0};
                    r_bit_cnt <= r_bit_cnt + BIT_CNT_W'(1);
                    if (r_bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_valid       <= 1'b1;
                    r_row_index   <= r_row[2:0];
                    r_pixels      <= n_pixels;
                    r_digit_count <= n_digit_count;
                    r_last        <= (r_row == ROW_CNT_W'(GLYPH_ROWS - 1));
                    r_row         <= r_row + ROW_CNT_W'(1);
                    if (r_row == ROW_CNT_W'(GLYPH_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_row_index   = r_row_index;
    assign o_pixels_high = r_pixels[ROW_BITS-1:64];
    assign o_pixels_low  = r_pixels[63:0];
    assign o_digit_count = r_digit_count;
    assign o_last        = r_last;

endmodule

FILE: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddg_pkg::*;

    localparam int GLYPH_ROWS     = DEF_GLYPH_ROWS;
    localparam int GLYPH_WIDTH    = DEF_GLYPH_WIDTH;
    localparam int MAX_DIGITS     = DEF_MAX_DIGITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_GAP        = 60;

    // digit shapes, row 0 on top, msb is the leftmost pixel
    localparam logic [7:0] DIGIT_FONT [0:7][0:9] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3E, 8'h0C, 8'h1E, 8'h1E, 8'h06, 8'h3F, 8'h1E, 8'h7F, 8'h1E, 8'h1E},
        '{8'h63, 8'h1C, 8'h33, 8'h33, 8'h0E, 8'h30, 8'h33, 8'h03, 8'h33, 8'h33},
        '{8'h63, 8'h0C, 8'h33, 8'h03, 8'h16, 8'h30, 8'h30, 8'h06, 8'h33, 8'h33},
        '{8'h63, 8'h0C, 8'h06, 8'h0C, 8'h36, 8'h3E, 8'h3E, 8'h0C, 8'h1E, 8'h1F},
        '{8'h63, 8'h0C, 8'h0C, 8'h03, 8'h66, 8'h03, 8'h33, 8'h18, 8'h33, 8'h03},
        '{8'h63, 8'h0C, 8'h18, 8'h33, 8'h7F, 8'h03, 8'h33, 8'h30, 8'h33, 8'h33},
        '{8'h3E, 8'h3F, 8'h3F, 8'h1E, 8'h06, 8'h3E, 8'h1E, 8'h60, 8'h1E, 8'h1E}
    };

    typedef struct packed {
        logic [2:0]         row_index;
        logic [15:0]        pixels_high;
        logic [63:0]        pixels_low;
        logic [COUNT_W-1:0] digit_count;
        logic               last;
    } t_glyph_row;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 busy;
    logic                 o_valid;
    logic [2:0]           o_row_index;
    logic [15:0]          o_pixels_high;
    logic [63:0]          o_pixels_low;
    logic [COUNT_W-1:0]   o_digit_count;
    logic                 o_last;

    t_glyph_row expected_rows [$];
    int         error_count     = 0;
    int         sender_idle_pct = 22;
    int         quiet_cycles    = 0;

    decimal_digit_glyph_renderer #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_WIDTH (GLYPH_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_value       (i_value),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_row_index   (o_row_index),
        .o_pixels_high (o_pixels_high),
        .o_pixels_low  (o_pixels_low),
        .o_digit_count (o_digit_count),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // split into decimal digits and queue every glyph row of the value
    task automatic predict_glyph_rows(input logic [VALUE_W-1:0] value);
        logic [3:0]          dig [0:9];
        int                  count;
        int                  row;
        int                  c;
        logic [VALUE_W-1:0]  rest;
        logic [ROW_BITS-1:0] line;
        t_glyph_row          r;
        rest  = value;
        count = 0;
        do begin
            dig[count] = 4'(rest % 10);
            count++;
            rest = rest / 10;
        end while (rest != 0 && count < 10);
        for (row = 0; row < GLYPH_ROWS; row++) begin
            line = '0;
            for (c = 0; c < MAX_DIGITS; c++) begin
                if (c < count && row < 8) begin
                    line[c*GLYPH_WIDTH +: GLYPH_WIDTH] =
                        DIGIT_FONT[row][dig[c]][GLYPH_WIDTH-1:0];
                end
            end
            r.row_index   = 3'(row);
            r.pixels_high = line[79:64];
            r.pixels_low  = line[63:0];
            r.digit_count = COUNT_W'(count);
            r.last        = (row == GLYPH_ROWS - 1);
            expected_rows.push_back(r);
        end
    endtask

    // start stays high across back-to-back items, it is lowered only before a gap
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        predict_glyph_rows(value);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int     len;
        longint lo;
        longint hi;
        int     k;
        logic [VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: begin
                len = $urandom_range(10, 1);
                lo  = 1;
                for (k = 1; k < len; k++) begin
                    lo = lo * 10;
                end
                hi = (len == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
                v  = $urandom_range(32'(hi), 32'(lo));
            end
            2: v = $urandom_range(999);
            default: v = $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
        endcase
        return v;
    endfunction

    task automatic test_extremes();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'd999_999_999);
        send_value(32'd1_000_000_000);
        send_value(32'd4_294_967_295);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
    endtask

    // every digit shape in every cell position up to nine digits
    task automatic test_each_digit();
        int d;
        for (d = 1; d <= 9; d++) begin
            send_value(VALUE_W'(d * 111_111_111));
        end
        send_value(32'd1_234_567_890);
        send_value(32'd4_000_000_000);
    endtask

    task automatic test_random_values(input int idle_pct, input int n);
        int i;
        sender_idle_pct = idle_pct;
        for (i = 0; i < n; i++) begin
            send_value(pick_value());
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph_row want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_rows.size() == 0) begin
                report_mismatch("row with nothing pending, row_index", 64'(o_row_index), '0);
            end else begin
                want = expected_rows.pop_front();
                if (o_row_index !== want.row_index)
                    report_mismatch("row_index", 64'(o_row_index), 64'(want.row_index));
                if (o_pixels_high !== want.pixels_high)
                    report_mismatch("pixels_high", 64'(o_pixels_high), 64'(want.pixels_high));
                if (o_pixels_low !== want.pixels_low)
                    report_mismatch("pixels_low", o_pixels_low, want.pixels_low);
                if (o_digit_count !== want.digit_count)
                    report_mismatch("digit_count", 64'(o_digit_count), 64'(want.digit_count));
                if (o_last !== want.last)
                    report_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    // any transfer in or out restarts the count
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d rows pending", expected_rows.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_each_digit();
        test_random_values(22, 62);
        test_random_values(82, 62);
        test_random_values(0, 62);
        start <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
